// File: rtl/telemetry_frame_deframer_assert.svh
// Assertion macros shared by the deframer modules.
`ifndef TELEMETRY_FRAME_DEFRAMER_ASSERT_SVH
`define TELEMETRY_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset.
`define TFD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tfd assertion failed");

// Consequent checked in the cycle after the antecedent.
`define TFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfd assertion failed");

`else

`define TFD_ASSERT(lbl, prop)
`define TFD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/tfd_pkg.sv
// Shared constants and the queue entry type of the telemetry deframer.
`timescale 1ns / 1ps
package tfd_pkg;

    localparam logic [7:0] ESC_BYTE     = 8'h7D;
    localparam logic [7:0] ESC_ADD      = 8'h20;
    localparam logic [7:0] CHECK_BASE   = 8'hFF;
    localparam logic [7:0] MARKER_RESET = 8'h10;

    localparam int POS_W       = 3;
    localparam int FRAME_LEN   = 7;
    localparam int PAYLOAD_LEN = FRAME_LEN - 1;
    localparam int QUEUE_DEPTH = 2;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LAST  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  idx;
        logic [7:0]        data;
    } tfd_entry_t;

endpackage

// File: rtl/tfd_front.sv
// Front end: unescape, marker hunt and byte classification.
`timescale 1ns / 1ps
module tfd_front
    import tfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       frame_marker_we,
    input  logic [7:0] frame_marker_wdata,
    input  logic       q_full,
    output logic       q_push,
    output tfd_entry_t q_entry
);

    logic             esc_reg, esc_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       marker_reg;
    logic             accept;
    logic [7:0]       byte_eff;

    assign rx_stall = q_full;
    assign accept   = rx_valid && !q_full;
    assign byte_eff = esc_reg ? (rx_byte + ESC_ADD) : rx_byte;

    always_comb
    begin
        esc_next = esc_reg;
        pos_next = pos_reg;
        q_push   = 1'b0;
        q_entry  = '{kind: KIND_DATA, idx: pos_reg - 1'b1, data: byte_eff};
        if (accept)
        begin
            if (!esc_reg && (rx_byte == ESC_BYTE))
            begin
                esc_next = 1'b1;
            end
            else
            begin
                esc_next = 1'b0;
                if (pos_reg == '0)
                begin
                    // hunt for the marker; everything else is dropped
                    if (byte_eff == marker_reg)
                    begin
                        q_push       = 1'b1;
                        q_entry.kind = KIND_START;
                        q_entry.data = marker_reg;
                        pos_next     = POS_W'(1);
                    end
                end
                else if (pos_reg < POS_W'(FRAME_LEN))
                begin
                    q_push   = 1'b1;
                    pos_next = pos_reg + 1'b1;
                end
                else
                begin
                    q_push       = 1'b1;
                    q_entry.kind = KIND_LAST;
                    pos_next     = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg    <= 1'b0;
            pos_reg    <= '0;
            marker_reg <= MARKER_RESET;
        end
        else
        begin
            esc_reg <= esc_next;
            pos_reg <= pos_next;
            if (frame_marker_we)
            begin
                marker_reg <= frame_marker_wdata;
            end
        end
    end

endmodule

// File: rtl/tfd_queue.sv
// Short queue of classified bytes between front and back end.
`timescale 1ns / 1ps
`include "telemetry_frame_deframer_assert.svh"
module tfd_queue
    import tfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  tfd_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output tfd_entry_t pop_entry,
    output logic       empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tfd_entry_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `TFD_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH))
    `TFD_ASSERT(a_no_push_full, !(push && full))
    `TFD_ASSERT(a_no_pop_empty, !(pop && empty))

endmodule

// File: rtl/tfd_back.sv
// Back end: frame assembly, checksum, good-frame count and result register.
`timescale 1ns / 1ps
`include "telemetry_frame_deframer_assert.svh"
module tfd_back
    import tfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  tfd_entry_t  q_entry,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] frame_id,
    output logic [31:0] frame_value,
    output logic        check_ok,
    output logic [31:0] good_frames
);

    logic [7:0]  bytes_reg [PAYLOAD_LEN];
    logic [7:0]  sum_reg, sum_next;
    logic [31:0] good_reg, good_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] id_reg;
    logic [31:0] value_reg;
    logic        ok_reg;
    logic [31:0] good_out_reg;

    logic        load_ok;
    logic        is_last;
    logic        store;
    logic        load;
    logic        ok;
    logic [8:0]  sum9;
    logic [7:0]  folded;

    assign load_ok = !out_valid_reg || !out_stall;
    assign is_last = (q_entry.kind == KIND_LAST);
    assign q_pop   = !q_empty && (!is_last || load_ok);
    assign sum9    = {1'b0, sum_reg} + {1'b0, q_entry.data};
    // end-around carry
    assign folded  = sum9[7:0] + {7'b0, sum9[8]};
    assign ok      = ((CHECK_BASE - sum_reg) == q_entry.data);

    always_comb
    begin
        sum_next  = sum_reg;
        good_next = good_reg;
        store     = 1'b0;
        load      = 1'b0;
        if (q_pop)
        begin
            case (q_entry.kind)
                KIND_START:
                begin
                    sum_next = q_entry.data;
                end
                KIND_DATA:
                begin
                    store    = 1'b1;
                    sum_next = folded;
                end
                KIND_LAST:
                begin
                    load = 1'b1;
                    if (ok)
                    begin
                        good_next = good_reg + 1'b1;
                    end
                end
                default:
                begin
                    sum_next = sum_reg;
                end
            endcase
        end
        out_valid_next = load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (store && (q_entry.idx < POS_W'(PAYLOAD_LEN)))
        begin
            bytes_reg[q_entry.idx] <= q_entry.data;
        end
        if (load)
        begin
            id_reg       <= {bytes_reg[1], bytes_reg[0]};
            value_reg    <= {bytes_reg[5], bytes_reg[4], bytes_reg[3], bytes_reg[2]};
            ok_reg       <= ok;
            good_out_reg <= good_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= MARKER_RESET;
            good_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            good_reg      <= good_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_id    = id_reg;
    assign frame_value = value_reg;
    assign check_ok    = ok_reg;
    assign good_frames = good_out_reg;

    `TFD_ASSERT(a_last_needs_slot, !(q_pop && is_last && !load_ok))
    `TFD_ASSERT_NEXT(a_bad_frame_count, q_pop && is_last && !ok, $stable(good_reg))
    `TFD_ASSERT_NEXT(a_out_hold, out_valid_reg && out_stall, out_valid_reg && $stable(id_reg))

endmodule

// File: rtl/telemetry_frame_deframer.sv
// Top level of the telemetry frame deframer.
`timescale 1ns / 1ps
// Takes one received byte per clock on the rx channel while rx_stall is low
// and returns one result per completed eight-byte frame (id, value, check
// flag, good-frame count). The front end unescapes and classifies each byte
// in the cycle it is accepted; escape bytes and non-marker bytes seen while
// hunting leave nothing behind. Classified bytes pass through a queue
// of QUEUE_DEPTH entries to the back end, which retires one per cycle unless
// a last byte waits for the output register, and holds the finished frame
// there. Sustained rate is one byte per cycle; rx_stall rises only when the
// queue is full, which happens only while a result sits unread at the output.
module telemetry_frame_deframer
    import tfd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_marker_we,
    input  logic [7:0]  frame_marker_wdata,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] frame_id,
    output logic [31:0] frame_value,
    output logic        check_ok,
    output logic [31:0] good_frames
);

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    tfd_entry_t push_entry;
    tfd_entry_t pop_entry;

    tfd_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .rx_valid           (rx_valid),
        .rx_stall           (rx_stall),
        .rx_byte            (rx_byte),
        .frame_marker_we    (frame_marker_we),
        .frame_marker_wdata (frame_marker_wdata),
        .q_full             (q_full),
        .q_push             (q_push),
        .q_entry            (push_entry)
    );

    tfd_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    tfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_entry     (pop_entry),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_id    (frame_id),
        .frame_value (frame_value),
        .check_ok    (check_ok),
        .good_frames (good_frames)
    );

endmodule

// File: tb/telemetry_frame_deframer_tb.sv
// Self-checking testbench for the telemetry frame deframer.
`timescale 1ns / 1ps
module telemetry_frame_deframer_tb;
    import tfd_pkg::*;

    localparam int STUCK_LIMIT = 5000;
    localparam int DRAIN_PAD   = QUEUE_DEPTH + 6;
    localparam int PHASE_BYTES = 110;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] value;
        logic        ok;
        logic [31:0] good;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        frame_marker_we = 1'b0;
    logic [7:0]  frame_marker_wdata = 8'h00;
    logic        rx_valid = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] frame_id;
    logic [31:0] frame_value;
    logic        check_ok;
    logic [31:0] good_frames;

    // Deframer state mirrored by the predictor
    logic [7:0]  marker_reg = MARKER_RESET;
    logic        esc_seen = 1'b0;
    int          frame_pos = 0;
    logic [7:0]  frame_buf [FRAME_LEN];
    logic [7:0]  seed_sum = MARKER_RESET;
    logic [31:0] good_total = 32'd0;

    frame_result_t expected_frames[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int bytes_accepted = 0;
    int frame_bytes_sent = 0;
    int frames_checked = 0;
    int good_seen = 0;
    int marker_writes = 0;
    int stuck_cycles = 0;

    telemetry_frame_deframer uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .frame_marker_we    (frame_marker_we),
        .frame_marker_wdata (frame_marker_wdata),
        .rx_valid           (rx_valid),
        .rx_stall           (rx_stall),
        .rx_byte            (rx_byte),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .frame_id           (frame_id),
        .frame_value        (frame_value),
        .check_ok           (check_ok),
        .good_frames        (good_frames)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Ones-complement style add: fold the carry back into the low byte
    function automatic logic [7:0] fold_add(input logic [7:0] acc, input logic [7:0] v);
        logic [8:0] t;
        t = {1'b0, acc} + {1'b0, v};
        return t[7:0] + {7'd0, t[8]};
    endfunction

    task automatic deframe_byte(input logic [7:0] raw);
        logic [7:0]    b;
        int            idx;
        frame_result_t r;
        b = raw;
        if (!esc_seen && b == ESC_BYTE)
        begin
            esc_seen = 1'b1;
            return;
        end
        if (esc_seen)
        begin
            esc_seen = 1'b0;
            b = b + ESC_ADD;
        end
        if (frame_pos == 0)
        begin
            if (b == marker_reg)
            begin
                frame_pos = 1;
                seed_sum = marker_reg;
            end
            return;
        end
        idx = frame_pos - 1;
        frame_buf[idx] = b;
        if (idx < PAYLOAD_LEN)
            seed_sum = fold_add(seed_sum, b);
        if (frame_pos < FRAME_LEN)
        begin
            frame_pos++;
            return;
        end
        frame_pos = 0;
        r.ok = ((CHECK_BASE - seed_sum) == frame_buf[FRAME_LEN-1]);
        if (r.ok)
            good_total = good_total + 32'd1;
        r.id = {frame_buf[1], frame_buf[0]};
        r.value = {frame_buf[5], frame_buf[4], frame_buf[3], frame_buf[2]};
        r.good = good_total;
        expected_frames.push_back(r);
    endtask

    always @(posedge clk)
    begin : check_result
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_frames.size() == 0)
            begin
                errors++;
                $error("unexpected frame result: id %h value %h", frame_id, frame_value);
            end
            else
            begin
                want = expected_frames.pop_front();
                frames_checked++;
                if (check_ok)
                    good_seen++;
                if (frame_id !== want.id)
                begin
                    errors++;
                    $error("frame_id mismatch: expected %h, got %h", want.id, frame_id);
                end
                if (frame_value !== want.value)
                begin
                    errors++;
                    $error("frame_value mismatch: expected %h, got %h",
                           want.value, frame_value);
                end
                if (check_ok !== want.ok)
                begin
                    errors++;
                    $error("check_ok mismatch: expected %b, got %b", want.ok, check_ok);
                end
                if (good_frames !== want.good)
                begin
                    errors++;
                    $error("good_frames mismatch: expected %0d, got %0d",
                           want.good, good_frames);
                end
            end
        end
    end

    // Called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            rx_valid <= 1'b0;
            @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (rx_stall);
        deframe_byte(b);
        bytes_accepted++;
        @(negedge clk);
    endtask

    // Escape a frame byte when it must be, or at random when asked
    task automatic send_coded(input logic [7:0] b, input int esc_pct);
        frame_bytes_sent++;
        if (b == ESC_BYTE || $urandom_range(0, 99) < esc_pct)
        begin
            send_byte(ESC_BYTE);
            send_byte(b - ESC_ADD);
        end
        else
            send_byte(b);
    endtask

    task automatic send_frame(input logic [15:0] id, input logic [31:0] value,
                              input bit good, input int esc_pct);
        logic [47:0] payload;
        logic [7:0]  sum;
        logic [7:0]  chk;
        payload = {value, id};
        sum = marker_reg;
        send_coded(marker_reg, esc_pct);
        for (int i = 0; i < PAYLOAD_LEN; i++)
        begin
            sum = fold_add(sum, payload[8*i +: 8]);
            send_coded(payload[8*i +: 8], esc_pct);
        end
        chk = CHECK_BASE - sum;
        if (!good)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_coded(chk, esc_pct);
    endtask

    // Hold off until every result is out and the pipe has emptied
    task automatic wait_drained();
        rx_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(negedge clk);
    endtask

    task automatic write_marker(input logic [7:0] v);
        wait_drained();
        frame_marker_we <= 1'b1;
        frame_marker_wdata <= v;
        @(negedge clk);
        frame_marker_we <= 1'b0;
        marker_reg = v;
        marker_writes++;
    endtask

    function automatic logic [7:0] pick_marker(input int slot);
        case (slot)
            0: return 8'h00;
            1: return 8'hFF;
            2: return ESC_BYTE;
            3: return ESC_BYTE + ESC_ADD;
            7: return MARKER_RESET;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_id();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_field_extremes();
        send_byte(8'h00);
        send_frame(16'h0000, 32'hFFFF_FFFF, 1'b1, 0);
        send_frame(16'hFFFF, 32'h0000_0000, 1'b0, 0);
    endtask

    // Escaped marker, escape of an escape, marker as data, escaped 0x7D
    task automatic test_escape_cases();
        send_frame(16'h109D, 32'h00FF_007D, 1'b1, 100);
    endtask

    task automatic test_marker_change_mid_frame();
        logic [7:0] sum;
        logic [7:0] part [7];
        part[0] = 8'h34;
        part[1] = 8'h12;
        part[2] = 8'h78;
        part[3] = 8'h56;
        part[4] = MARKER_RESET;
        part[5] = 8'hFF;
        sum = marker_reg;
        send_byte(marker_reg);
        for (int i = 0; i < 3; i++)
        begin
            sum = fold_add(sum, part[i]);
            send_byte(part[i]);
        end
        write_marker(8'hFF);
        // Old seed still applies to this frame
        for (int i = 3; i < PAYLOAD_LEN; i++)
        begin
            sum = fold_add(sum, part[i]);
            send_byte(part[i]);
        end
        send_byte(CHECK_BASE - sum);
        send_frame(16'hA5A5, 32'h1234_5678, 1'b1, 0);
    endtask

    task automatic test_random_traffic(input int phase, input int send_pct,
                                       input int stall_pct_v);
        int target;
        int roll;
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct_v;
        for (int k = 0; k < 4; k++)
        begin
            write_marker(pick_marker(phase * 4 + k));
            target = frame_bytes_sent + PHASE_BYTES;
            while (frame_bytes_sent < target)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 75)
                    send_frame(pick_id(), pick_value(), $urandom_range(0, 99) < 85, 10);
                else if (roll < 88)
                begin
                    // Line noise: stray escapes, markers and junk
                    repeat ($urandom_range(1, 4))
                    begin
                        case ($urandom_range(0, 3))
                            0: send_byte(ESC_BYTE);
                            1: send_byte(marker_reg);
                            default: send_byte(8'($urandom));
                        endcase
                    end
                end
                else
                begin
                    // Cut-off frame: following bytes complete it
                    send_coded(marker_reg, 10);
                    repeat ($urandom_range(1, 5)) send_coded(8'($urandom), 10);
                end
            end
        end
    endtask

    initial
    begin : watchdog
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (rx_valid && !rx_stall) || (out_valid && !out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : main
        send_idle_pct = 17;
        recv_stall_pct = 76;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_field_extremes();
        test_escape_cases();
        test_marker_change_mid_frame();

        test_random_traffic(0, 17, 76);
        test_random_traffic(1, 76, 17);
        test_random_traffic(2, 0, 0);

        wait_drained();
        repeat (20) @(posedge clk);
        if (expected_frames.size() != 0)
        begin
            errors++;
            $error("%0d frame results never arrived", expected_frames.size());
        end

        $display("Fed %0d bytes (%0d frame bytes) across %0d marker settings",
                 bytes_accepted, frame_bytes_sent, marker_writes);
        $display("and three idle mixes; compared %0d frame results, %0d with a good check.",
                 frames_checked, good_seen);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
